[hdl/ebcpu_pkg.sv]
// ----------------------------------------------------------------------------
// ebcpu_pkg
// Shared types and constants of the eight-bit CPU execute block: instruction
// field layout, opcode codes, compare codes, memory geometry and result layout.
// ----------------------------------------------------------------------------
package ebcpu_pkg;

   // Instruction and data widths
   localparam int INSTR_W  = 16;
   localparam int FIELD_W  = 4;
   localparam int DATA_W   = 8;
   localparam int PC_W     = 16;
   localparam int NUM_REGS = 16;

   // Data store: 256 segments of 256 bytes, addressed as {segment, offset}
   localparam int DMEM_AW    = 2 * DATA_W;
   localparam int DMEM_DEPTH = 1 << DMEM_AW;

   // Stores to this segment and above hit ROM
   localparam logic [DATA_W-1:0] ROM_FIRST_SEGMENT = 8'd128;

   // Result transfer width: 16 + 1 + 4 + 8 + 1 + 1 + 1 bits
   localparam int RSP_W = PC_W + 1 + FIELD_W + DATA_W + 3;

   // Major opcodes, bits 15:12; code 15 acts as a no-op
   typedef enum logic [FIELD_W-1:0] {
      OP_EXT  = 4'd0,
      OP_ADD  = 4'd1,
      OP_SUB  = 4'd2,
      OP_ADDC = 4'd3,
      OP_SUBC = 4'd4,
      OP_CMP  = 4'd5,
      OP_JLT  = 4'd6,
      OP_JGT  = 4'd7,
      OP_JEQ  = 4'd8,
      OP_LDR  = 4'd9,
      OP_STR  = 4'd10,
      OP_LRC  = 4'd11,
      OP_AND  = 4'd12,
      OP_OR   = 4'd13,
      OP_XOR  = 4'd14
   } op_type;

   // Extended sub-ops in field a; codes 8..15 act as no-ops
   typedef enum logic [FIELD_W-1:0] {
      EXT_STOP  = 4'd0,
      EXT_CPY   = 4'd1,
      EXT_NOT   = 4'd2,
      EXT_LSL   = 4'd3,
      EXT_LSR   = 4'd4,
      EXT_JMP   = 4'd5,
      EXT_NOP   = 4'd6,
      EXT_BREAK = 4'd7
   } ext_type;

   // Compare results as written by CMP and tested by the conditional jumps
   localparam logic [DATA_W-1:0] CMP_LT = 8'd0;
   localparam logic [DATA_W-1:0] CMP_EQ = 8'd1;
   localparam logic [DATA_W-1:0] CMP_GT = 8'd2;

   // One result item
   typedef struct packed {
      logic                break_entered;
      logic                rom_write_fault;
      logic                halt_now;
      logic [DATA_W-1:0]   dest_value;
      logic [FIELD_W-1:0]  dest_register;
      logic                reg_write;
      logic [PC_W-1:0]     next_pc;
   } rsp_type;

endpackage

[hdl/eight_bit_cpu_execute.sv]
// ----------------------------------------------------------------------------
// eight_bit_cpu_execute
// Executes one 16-bit instruction word per input transfer against a register
// file, a program counter, a 64 KiB data store and a halt flag.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : instruction words in, one transfer per instruction.
//   rsp_*  : one result transfer per instruction, in order.
//   csr_*  : debug_mode write, only while the block is idle.
// Each instruction is registered into the execute stage at the input
//   transfer, its result into the output register when it executes.
// Throughput: one instruction per cycle when the output does not stall;
//   LDR waits for its data store read. The register file is read at the
//   input transfer and written at retire; a one-entry bypass covers the
//   back-to-back read of a register written in the same cycle.
// Reset: registers, pc, halt and debug_mode clear at once; the data store is
//   then swept to zero, one byte a cycle over all 65536 bytes, and req_tready
//   stays low while it runs. Configuration writes are taken during the sweep.
// Stall: the result sits in the output register; the execute stage keeps
//   its instruction and req_tready drops when both are full.
// ----------------------------------------------------------------------------
module eight_bit_cpu_execute (
   input  logic                              clock,
   input  logic                              reset,
   // Instruction stream. tdata: instruction_word[15:0]
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [ebcpu_pkg::INSTR_W-1:0]     req_tdata,
   // Result stream. tdata: next_pc[15:0], reg_write[16], dest_register[20:17],
   // dest_value[28:21], halt_now[29], rom_write_fault[30], break_entered[31]
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [ebcpu_pkg::RSP_W-1:0]       rsp_tdata,
   // debug_mode register
   input  logic                              csr_wr_en,
   input  logic                              csr_wr_data
);

   localparam int DW = ebcpu_pkg::DATA_W;
   localparam int FW = ebcpu_pkg::FIELD_W;
   localparam int PW = ebcpu_pkg::PC_W;
   localparam int AW = ebcpu_pkg::DMEM_AW;

   // Memories: two copies of the register file for three read ports
   logic [DW-1:0] rf_a_mem  [ebcpu_pkg::NUM_REGS];
   logic [DW-1:0] rf_bc_mem [ebcpu_pkg::NUM_REGS];
   logic [DW-1:0] dmem      [ebcpu_pkg::DMEM_DEPTH];

   // Control state
   logic                        clear_ff;
   logic [AW-1:0]               clr_addr_ff;
   logic                        debug_ff;
   logic                        halted_ff, halted_in;
   logic [PW-1:0]               pc_ff;
   logic                        s2_valid_ff;
   logic                        s2_phase_ff;
   logic                        rsp_valid_ff;
   logic [ebcpu_pkg::NUM_REGS-1:0] rf_vld_ff;

   // Execute stage payload
   logic [ebcpu_pkg::INSTR_W-1:0] s2_instr_ff;
   logic [DW-1:0]  qa_ff, qb_ff, qc_ff;
   logic           va_ff, vb_ff, vc_ff;
   logic           ha_ff, hb_ff, hc_ff;
   logic [DW-1:0]  byp_ff;
   logic [DW-1:0]  dmem_q_ff;
   ebcpu_pkg::rsp_type rsp_ff;

   // Handshake and execute signals
   logic           req_fire;
   logic           out_free;
   logic           need_wait;
   logic           exec_fire;
   logic [FW-1:0]  fa_new, fb_new, fc_new;
   ebcpu_pkg::op_type  op;
   ebcpu_pkg::ext_type ext;
   logic [FW-1:0]  fa, fb, fc;
   logic [DW-1:0]  ra, rb, rc, imm;
   logic [PW-1:0]  npc;
   logic           wr;
   logic [FW-1:0]  dreg;
   logic [DW-1:0]  dval;
   logic           fault;
   logic           brk;
   logic           rf_we;
   logic           st_we;
   logic           ld_rd;

   // Handshake
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = !clear_ff && (!s2_valid_ff || exec_fire);
   assign req_fire   = req_tvalid && req_tready;

   assign fa_new = req_tdata[3*FW-1:2*FW];
   assign fb_new = req_tdata[2*FW-1:FW];
   assign fc_new = req_tdata[FW-1:0];

   // Decode the instruction in the execute stage
   assign op  = ebcpu_pkg::op_type'(s2_instr_ff[4*FW-1:3*FW]);
   assign fa  = s2_instr_ff[3*FW-1:2*FW];
   assign fb  = s2_instr_ff[2*FW-1:FW];
   assign fc  = s2_instr_ff[FW-1:0];
   assign ext = ebcpu_pkg::ext_type'(fa);
   assign imm = {fb, fc};

   // Operands: bypass first, then stored value, never-written reads as zero
   assign ra = ha_ff ? byp_ff : (va_ff ? qa_ff : '0);
   assign rb = hb_ff ? byp_ff : (vb_ff ? qb_ff : '0);
   assign rc = hc_ff ? byp_ff : (vc_ff ? qc_ff : '0);

   // LDR waits for the data store read
   assign need_wait = (op == ebcpu_pkg::OP_LDR) && !halted_ff && !s2_phase_ff;
   assign exec_fire = s2_valid_ff && !need_wait && out_free;
   assign ld_rd     = s2_valid_ff && need_wait;

   // Execute
   always_comb begin
      npc       = pc_ff + PW'(1);
      wr        = 1'b0;
      dreg      = '0;
      dval      = '0;
      fault     = 1'b0;
      brk       = 1'b0;
      halted_in = halted_ff;
      if (halted_ff) begin
         npc = pc_ff;
      end else begin
         case (op)
            ebcpu_pkg::OP_EXT: begin
               case (ext)
                  ebcpu_pkg::EXT_STOP: begin
                     halted_in = 1'b1;
                     npc       = pc_ff;
                  end
                  ebcpu_pkg::EXT_CPY: begin
                     wr = 1'b1; dreg = fb; dval = rc;
                  end
                  ebcpu_pkg::EXT_NOT: begin
                     wr = 1'b1; dreg = fb; dval = ~rc;
                  end
                  ebcpu_pkg::EXT_LSL: begin
                     wr = 1'b1; dreg = fb;
                     dval = (rc[DW-1:3] != '0) ? '0 : (rb << rc[2:0]);
                  end
                  ebcpu_pkg::EXT_LSR: begin
                     wr = 1'b1; dreg = fb;
                     dval = (rc[DW-1:3] != '0) ? '0 : (rb >> rc[2:0]);
                  end
                  ebcpu_pkg::EXT_JMP: npc = {rb, rc};
                  ebcpu_pkg::EXT_BREAK: brk = debug_ff;
                  default: ;
               endcase
            end
            ebcpu_pkg::OP_ADD: begin
               wr = 1'b1; dreg = fa; dval = rb + rc;
            end
            ebcpu_pkg::OP_SUB: begin
               wr = 1'b1; dreg = fa; dval = rb - rc;
            end
            ebcpu_pkg::OP_ADDC: begin
               wr = 1'b1; dreg = fa; dval = ra + imm;
            end
            ebcpu_pkg::OP_SUBC: begin
               wr = 1'b1; dreg = fa; dval = ra - imm;
            end
            ebcpu_pkg::OP_CMP: begin
               wr = 1'b1; dreg = fa;
               dval = (rb < rc) ? ebcpu_pkg::CMP_LT :
                      ((rb > rc) ? ebcpu_pkg::CMP_GT : ebcpu_pkg::CMP_EQ);
            end
            ebcpu_pkg::OP_JLT: if (ra == ebcpu_pkg::CMP_LT) npc = {rb, rc};
            ebcpu_pkg::OP_JGT: if (ra == ebcpu_pkg::CMP_GT) npc = {rb, rc};
            ebcpu_pkg::OP_JEQ: if (ra == ebcpu_pkg::CMP_EQ) npc = {rb, rc};
            ebcpu_pkg::OP_LDR: begin
               wr = 1'b1; dreg = fa; dval = dmem_q_ff;
            end
            ebcpu_pkg::OP_STR: begin
               if (rb >= ebcpu_pkg::ROM_FIRST_SEGMENT) begin
                  fault     = 1'b1;
                  halted_in = 1'b1;
                  npc       = pc_ff;
               end
            end
            ebcpu_pkg::OP_LRC: begin
               wr = 1'b1; dreg = fa; dval = imm;
            end
            ebcpu_pkg::OP_AND: begin
               wr = 1'b1; dreg = fa; dval = rb & rc;
            end
            ebcpu_pkg::OP_OR: begin
               wr = 1'b1; dreg = fa; dval = rb | rc;
            end
            ebcpu_pkg::OP_XOR: begin
               wr = 1'b1; dreg = fa; dval = rb ^ rc;
            end
            default: ;
         endcase
      end
   end

   assign rf_we = exec_fire && wr;
   assign st_we = exec_fire && !halted_ff && (op == ebcpu_pkg::OP_STR) && !fault;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff     <= 1'b1;
         clr_addr_ff  <= '0;
         debug_ff     <= 1'b0;
         halted_ff    <= 1'b0;
         pc_ff        <= '0;
         s2_valid_ff  <= 1'b0;
         s2_phase_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rf_vld_ff    <= '0;
      end else begin
         // Sweep the data store after reset
         if (clear_ff) begin
            clr_addr_ff <= clr_addr_ff + AW'(1);
            if (clr_addr_ff == '1) begin
               clear_ff <= 1'b0;
            end
         end
         if (csr_wr_en) begin
            debug_ff <= csr_wr_data;
         end
         // Advance the execute stage
         if (req_fire) begin
            s2_valid_ff <= 1'b1;
         end else if (exec_fire) begin
            s2_valid_ff <= 1'b0;
         end
         if (exec_fire) begin
            s2_phase_ff <= 1'b0;
         end else if (ld_rd) begin
            s2_phase_ff <= 1'b1;
         end
         // Retire: pc, halt, register valid bits
         if (exec_fire) begin
            halted_ff <= halted_in;
            pc_ff     <= npc;
         end
         if (rf_we) begin
            rf_vld_ff[dreg] <= 1'b1;
         end
         // Output register
         if (exec_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Register file: write at retire, read at the input transfer
   always_ff @(posedge clock) begin
      if (rf_we) begin
         rf_a_mem[dreg]  <= dval;
         rf_bc_mem[dreg] <= dval;
      end
      if (req_fire) begin
         qa_ff <= rf_a_mem[fa_new];
         qb_ff <= rf_bc_mem[fb_new];
         qc_ff <= rf_bc_mem[fc_new];
      end
   end

   // Capture valid bits and the same-cycle bypass with the read
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s2_instr_ff <= req_tdata;
         va_ff  <= rf_vld_ff[fa_new];
         vb_ff  <= rf_vld_ff[fb_new];
         vc_ff  <= rf_vld_ff[fc_new];
         ha_ff  <= rf_we && (dreg == fa_new);
         hb_ff  <= rf_we && (dreg == fb_new);
         hc_ff  <= rf_we && (dreg == fc_new);
         byp_ff <= dval;
      end
   end

   // Data store: sweep or STR write, LDR read
   always_ff @(posedge clock) begin
      if (clear_ff) begin
         dmem[clr_addr_ff] <= '0;
      end else if (st_we) begin
         dmem[{rb, rc}] <= ra;
      end
      if (ld_rd) begin
         dmem_q_ff <= dmem[{rb, rc}];
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (exec_fire) begin
         rsp_ff.next_pc         <= npc;
         rsp_ff.reg_write       <= wr;
         rsp_ff.dest_register   <= dreg;
         rsp_ff.dest_value      <= dval;
         rsp_ff.halt_now        <= halted_in;
         rsp_ff.rom_write_fault <= fault;
         rsp_ff.break_entered   <= brk;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

   // Checks
   a_no_accept_clear: assert property (@(posedge clock) disable iff (reset)
      clear_ff |-> !req_tready)
      else $error("instruction accepted during data store sweep");

   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> halted_ff)
      else $error("halt flag cleared without reset");

   a_ldr_interlock: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && need_wait) |-> !req_tready)
      else $error("instruction accepted while load waits for data");

   a_fault_halts: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.rom_write_fault) |-> (rsp_ff.halt_now && halted_ff))
      else $error("ROM store fault without halt");

endmodule

[test/eight_bit_cpu_execute_tb.sv]
// ----------------------------------------------------------------------------
// eight_bit_cpu_execute_tb
// Self-checking bench for the eight-bit CPU execute block. A behavioral
// predictor keeps its own register file, pc, data store, halt flag and
// debug_mode, works out the result of every instruction word and checks each
// result transfer field by field. Stimulus is a short directed program
// followed by random bursts (memory round trips, compare and branch, shifts,
// plain noise) under three idling mixes, then one program stop at the end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module eight_bit_cpu_execute_tb;

   typedef enum int {
      PH_SETUP, PH_RECV_SLOW, PH_SEND_SLOW, PH_STEADY, PH_STOP
   } phase_type;

   localparam int ITEMS_PER_PHASE = 300;
   localparam int HOLD_CYCLES     = 80;

   logic                                clock;
   logic                                reset       = 1'b1;
   logic                                req_tvalid  = 1'b0;
   logic                                req_tready;
   logic [ebcpu_pkg::INSTR_W-1:0]       req_tdata   = '0;
   logic                                rsp_tvalid;
   logic                                rsp_tready  = 1'b0;
   logic [ebcpu_pkg::RSP_W-1:0]         rsp_tdata;
   logic                                csr_wr_en   = 1'b0;
   logic                                csr_wr_data = 1'b0;

   // Predicted architectural state
   logic [ebcpu_pkg::DATA_W-1:0]        arch_regs [ebcpu_pkg::NUM_REGS];
   logic [ebcpu_pkg::DATA_W-1:0]        arch_mem [ebcpu_pkg::DMEM_DEPTH];
   logic [ebcpu_pkg::PC_W-1:0]          arch_pc     = '0;
   logic                                arch_halted = 1'b0;
   logic                                dbg_mode    = 1'b0;

   // Words waiting to be driven, their predicted results, results due
   logic [ebcpu_pkg::INSTR_W-1:0]       instr_q[$];
   ebcpu_pkg::rsp_type                  planned_q[$];
   ebcpu_pkg::rsp_type                  expected_q[$];

   phase_type            phase         = PH_SETUP;
   int unsigned          send_idle_pct = 0;
   int unsigned          recv_idle_pct = 0;
   logic                 allow_stop    = 1'b0;
   logic                 req_done      = 1'b0;
   int unsigned          hold_left     = 0;
   logic                 hold_done     = 1'b0;

   int unsigned          fail_count    = 0;
   int unsigned          queued_items  = 0;
   int unsigned          checked_count = 0;
   int unsigned          write_count   = 0;
   int unsigned          jump_count    = 0;
   int unsigned          store_count   = 0;
   int unsigned          break_count   = 0;

   eight_bit_cpu_execute dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Give up long after the slowest correct run, clearing sweep included
   initial begin
      #3_000_000;
      $display("eight_bit_cpu_execute regression: fail");
      $finish;
   end

   function automatic logic [ebcpu_pkg::INSTR_W-1:0] instr_word(
         logic [3:0] op, logic [3:0] fa, logic [3:0] fb, logic [3:0] fc);
      return {op, fa, fb, fc};
   endfunction

   // Execute one word against the predicted state and return its result
   function automatic ebcpu_pkg::rsp_type execute_instr(
         logic [ebcpu_pkg::INSTR_W-1:0] word);
      ebcpu_pkg::rsp_type           r;
      ebcpu_pkg::op_type            op;
      ebcpu_pkg::ext_type           sub;
      logic [3:0]                   fa, fb, fc;
      logic [ebcpu_pkg::DATA_W-1:0] va, vb, vc, imm;
      logic                         wr;
      logic [3:0]                   dreg;
      logic [ebcpu_pkg::DATA_W-1:0] dval;
      logic [ebcpu_pkg::PC_W-1:0]   npc;
      op   = ebcpu_pkg::op_type'(word[15:12]);
      fa   = word[11:8];
      fb   = word[7:4];
      fc   = word[3:0];
      sub  = ebcpu_pkg::ext_type'(fa);
      va   = arch_regs[fa];
      vb   = arch_regs[fb];
      vc   = arch_regs[fc];
      imm  = word[7:0];
      wr   = 1'b0;
      dreg = '0;
      dval = '0;
      r    = '0;
      npc  = arch_pc + 16'd1;
      if (arch_halted) begin
         npc = arch_pc;
      end else begin
         case (op)
            ebcpu_pkg::OP_EXT: begin
               case (sub)
                  ebcpu_pkg::EXT_STOP: begin
                     arch_halted = 1'b1;
                     npc = arch_pc;
                  end
                  ebcpu_pkg::EXT_CPY: begin wr = 1'b1; dreg = fb; dval = vc; end
                  ebcpu_pkg::EXT_NOT: begin wr = 1'b1; dreg = fb; dval = ~vc; end
                  ebcpu_pkg::EXT_LSL: begin
                     wr = 1'b1; dreg = fb; dval = (vc >= 8) ? '0 : vb << vc;
                  end
                  ebcpu_pkg::EXT_LSR: begin
                     wr = 1'b1; dreg = fb; dval = (vc >= 8) ? '0 : vb >> vc;
                  end
                  ebcpu_pkg::EXT_JMP: npc = {vb, vc};
                  ebcpu_pkg::EXT_BREAK: r.break_entered = dbg_mode;
                  default: ;
               endcase
            end
            ebcpu_pkg::OP_ADD:  begin wr = 1'b1; dreg = fa; dval = vb + vc; end
            ebcpu_pkg::OP_SUB:  begin wr = 1'b1; dreg = fa; dval = vb - vc; end
            ebcpu_pkg::OP_ADDC: begin wr = 1'b1; dreg = fa; dval = va + imm; end
            ebcpu_pkg::OP_SUBC: begin wr = 1'b1; dreg = fa; dval = va - imm; end
            ebcpu_pkg::OP_CMP: begin
               wr = 1'b1;
               dreg = fa;
               dval = (vb < vc) ? ebcpu_pkg::CMP_LT :
                      ((vb > vc) ? ebcpu_pkg::CMP_GT : ebcpu_pkg::CMP_EQ);
            end
            ebcpu_pkg::OP_JLT: if (va == ebcpu_pkg::CMP_LT) npc = {vb, vc};
            ebcpu_pkg::OP_JGT: if (va == ebcpu_pkg::CMP_GT) npc = {vb, vc};
            ebcpu_pkg::OP_JEQ: if (va == ebcpu_pkg::CMP_EQ) npc = {vb, vc};
            ebcpu_pkg::OP_LDR: begin
               wr = 1'b1; dreg = fa; dval = arch_mem[{vb, vc}];
            end
            ebcpu_pkg::OP_STR: begin
               if (vb >= ebcpu_pkg::ROM_FIRST_SEGMENT) begin
                  r.rom_write_fault = 1'b1;
                  arch_halted = 1'b1;
                  npc = arch_pc;
               end else begin
                  arch_mem[{vb, vc}] = va;
                  store_count++;
               end
            end
            ebcpu_pkg::OP_LRC:  begin wr = 1'b1; dreg = fa; dval = imm; end
            ebcpu_pkg::OP_AND:  begin wr = 1'b1; dreg = fa; dval = vb & vc; end
            ebcpu_pkg::OP_OR:   begin wr = 1'b1; dreg = fa; dval = vb | vc; end
            ebcpu_pkg::OP_XOR:  begin wr = 1'b1; dreg = fa; dval = vb ^ vc; end
            default: ;
         endcase
         if (wr) begin
            arch_regs[dreg] = dval;
            write_count++;
         end
         if (npc != arch_pc + 16'd1 && !arch_halted)
            jump_count++;
         if (r.break_entered)
            break_count++;
         arch_pc = npc;
      end
      r.next_pc       = npc;
      r.reg_write     = wr;
      r.dest_register = dreg;
      r.dest_value    = dval;
      r.halt_now      = arch_halted;
      return r;
   endfunction

   // Queue a word with its prediction; keep the machine running unless a stop is due
   task automatic queue_instr(logic [ebcpu_pkg::INSTR_W-1:0] word);
      if (!allow_stop) begin
         if (word[15:12] == ebcpu_pkg::OP_STR &&
             arch_regs[word[7:4]] >= ebcpu_pkg::ROM_FIRST_SEGMENT)
            word[15:12] = ebcpu_pkg::OP_LDR;
         if (word[15:12] == ebcpu_pkg::OP_EXT && word[11:8] == ebcpu_pkg::EXT_STOP)
            word[11:8] = ebcpu_pkg::EXT_NOP;
      end
      planned_q.push_back(execute_instr(word));
      instr_q.push_back(word);
      queued_items++;
   endtask

   // One random burst: mostly well-formed sequences, some raw noise
   task automatic queue_random_burst();
      int unsigned                  kind;
      logic [3:0]                   ra, rb, rc, rd;
      logic [ebcpu_pkg::DATA_W-1:0] seg, off;
      kind = $urandom_range(0, 9);
      rb   = 4'($urandom_range(0, 15));
      rc   = rb + 4'd1;
      ra   = rb + 4'd2;
      rd   = 4'($urandom_range(0, 15));
      // Reuse a handful of addresses so loads often find earlier stores
      seg  = $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 127));
      off  = $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));
      case (kind)
         0, 1, 2: queue_instr(16'($urandom_range(0, 65535)));
         3, 4: begin
            queue_instr({ebcpu_pkg::OP_LRC, rb, seg});
            queue_instr({ebcpu_pkg::OP_LRC, rc, off});
            queue_instr({4'(ebcpu_pkg::OP_LRC), ra, 8'($urandom_range(0, 255))});
            queue_instr(instr_word(ebcpu_pkg::OP_STR, ra, rb, rc));
            if ($urandom_range(0, 1))
               queue_instr(16'($urandom_range(0, 65535)));
            queue_instr(instr_word(ebcpu_pkg::OP_LDR, rd, rb, rc));
         end
         5, 6: begin
            queue_instr(instr_word(ebcpu_pkg::OP_CMP, ra, 4'($urandom_range(0, 15)),
                                   4'($urandom_range(0, 15))));
            queue_instr(instr_word(4'($urandom_range(ebcpu_pkg::OP_JLT, ebcpu_pkg::OP_JEQ)),
                                   ra, rb, rc));
         end
         7: begin
            queue_instr({4'(ebcpu_pkg::OP_LRC), rc, 8'($urandom_range(0, 10))});
            queue_instr(instr_word(ebcpu_pkg::OP_EXT,
                                   $urandom_range(0, 1) ? ebcpu_pkg::EXT_LSL
                                                        : ebcpu_pkg::EXT_LSR, rb, rc));
         end
         8: queue_instr(instr_word(4'($urandom_range(ebcpu_pkg::OP_ADD, ebcpu_pkg::OP_XOR)),
                                   ra, rb, rc));
         default: queue_instr(instr_word(ebcpu_pkg::OP_EXT, 4'($urandom_range(0, 15)),
                                         rb, rc));
      endcase
   endtask

   task automatic write_debug(logic value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      dbg_mode = value;
   endtask

   // Hold the sender until every queued word is accepted and answered
   task automatic drain();
      while (planned_q.size() != 0 || expected_q.size() != 0)
         @(posedge clock);
   endtask

   task automatic run_random_phase(phase_type ph, int unsigned send_pct,
                                   int unsigned recv_pct);
      int unsigned target;
      @(posedge clock);
      phase         = ph;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      target        = queued_items + ITEMS_PER_PHASE;
      while (queued_items < target)
         queue_random_burst();
      drain();
   endtask

   function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         fail_count++;
      end
   endfunction

   // Drive the instruction stream; hold the word until its transfer
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_done) begin
         if (instr_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_tdata  <= instr_q.pop_front();
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Result backpressure, with one long hold-off at the start of the steady phase
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (phase == PH_STEADY && !hold_done) begin
         rsp_tready <= 1'b0;
         hold_left  <= HOLD_CYCLES;
         hold_done  <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // Move predictions to the due list on input transfers; check result transfers
   always @(posedge clock) begin : monitor
      ebcpu_pkg::rsp_type got, want;
      req_done = 1'b0;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = ebcpu_pkg::rsp_type'(rsp_tdata);
            if (expected_q.size() == 0) begin
               $error("result transfer with nothing outstanding: 0x%0h", rsp_tdata);
               fail_count++;
            end else begin
               want = expected_q.pop_front();
               check_field("next_pc", want.next_pc, got.next_pc);
               check_field("reg_write", 16'(want.reg_write), 16'(got.reg_write));
               check_field("dest_register", 16'(want.dest_register),
                           16'(got.dest_register));
               check_field("dest_value", 16'(want.dest_value), 16'(got.dest_value));
               check_field("halt_now", 16'(want.halt_now), 16'(got.halt_now));
               check_field("rom_write_fault", 16'(want.rom_write_fault),
                           16'(got.rom_write_fault));
               check_field("break_entered", 16'(want.break_entered),
                           16'(got.break_entered));
               checked_count++;
            end
         end
         if (req_tvalid && req_tready) begin
            req_done = 1'b1;
            if (planned_q.size() != 0)
               expected_q.push_back(planned_q.pop_front());
         end
      end
   end

   initial begin : stimulus
      logic halt_first;
      arch_regs = '{default: '0};
      arch_mem  = '{default: '0};

      repeat (11) @(negedge clock);
      reset <= 1'b0;
      write_debug(1'b0);

      // Directed program: wraps, compares, every jump, shifts, memory, unused codes
      queue_instr({ebcpu_pkg::OP_LRC, 4'd1, 8'hFF});
      queue_instr({ebcpu_pkg::OP_LRC, 4'd2, 8'h01});
      queue_instr(instr_word(ebcpu_pkg::OP_ADD, 4'd3, 4'd1, 4'd2));
      queue_instr(instr_word(ebcpu_pkg::OP_SUB, 4'd4, 4'd0, 4'd2));
      queue_instr({ebcpu_pkg::OP_ADDC, 4'd5, 8'hFF});
      queue_instr({ebcpu_pkg::OP_SUBC, 4'd5, 8'h80});
      queue_instr(instr_word(ebcpu_pkg::OP_CMP, 4'd6, 4'd1, 4'd2));
      queue_instr(instr_word(ebcpu_pkg::OP_CMP, 4'd7, 4'd2, 4'd1));
      queue_instr(instr_word(ebcpu_pkg::OP_CMP, 4'd8, 4'd2, 4'd2));
      queue_instr(instr_word(ebcpu_pkg::OP_JGT, 4'd6, 4'd1, 4'd2));
      queue_instr(instr_word(ebcpu_pkg::OP_JLT, 4'd7, 4'd2, 4'd1));
      queue_instr(instr_word(ebcpu_pkg::OP_JEQ, 4'd8, 4'd0, 4'd0));
      queue_instr(instr_word(ebcpu_pkg::OP_JLT, 4'd6, 4'd1, 4'd1));
      queue_instr(instr_word(ebcpu_pkg::OP_EXT, ebcpu_pkg::EXT_JMP, 4'd5, 4'd4));
      queue_instr(instr_word(ebcpu_pkg::OP_EXT, ebcpu_pkg::EXT_CPY, 4'd9, 4'd1));
      queue_instr(instr_word(ebcpu_pkg::OP_EXT, ebcpu_pkg::EXT_NOT, 4'd10, 4'd0));
      queue_instr({ebcpu_pkg::OP_LRC, 4'd11, 8'h07});
      queue_instr(instr_word(ebcpu_pkg::OP_EXT, ebcpu_pkg::EXT_LSL, 4'd2, 4'd11));
      queue_instr(instr_word(ebcpu_pkg::OP_EXT, ebcpu_pkg::EXT_LSR, 4'd9, 4'd11));
      queue_instr({ebcpu_pkg::OP_LRC, 4'd12, 8'h08});
      queue_instr(instr_word(ebcpu_pkg::OP_EXT, ebcpu_pkg::EXT_LSL, 4'd1, 4'd12));
      queue_instr(instr_word(ebcpu_pkg::OP_EXT, ebcpu_pkg::EXT_LSR, 4'd10, 4'd12));
      queue_instr(instr_word(ebcpu_pkg::OP_STR, 4'd5, 4'd5, 4'd4));
      queue_instr(instr_word(ebcpu_pkg::OP_LDR, 4'd13, 4'd5, 4'd4));
      queue_instr(instr_word(ebcpu_pkg::OP_AND, 4'd14, 4'd5, 4'd4));
      queue_instr(instr_word(ebcpu_pkg::OP_OR, 4'd15, 4'd2, 4'd5));
      queue_instr(instr_word(ebcpu_pkg::OP_XOR, 4'd13, 4'd13, 4'd4));
      queue_instr(instr_word(ebcpu_pkg::OP_EXT, ebcpu_pkg::EXT_BREAK, 4'd0, 4'd0));
      queue_instr(16'hFFFF);
      drain();

      // Breakpoint with debug on, then the random phases
      write_debug(1'b1);
      queue_instr(instr_word(ebcpu_pkg::OP_EXT, ebcpu_pkg::EXT_BREAK, 4'd3, 4'd7));
      queue_instr(instr_word(ebcpu_pkg::OP_EXT, ebcpu_pkg::EXT_NOP, 4'd15, 4'd15));
      run_random_phase(PH_RECV_SLOW, 38, 68);
      write_debug(1'b0);
      run_random_phase(PH_SEND_SLOW, 68, 38);
      write_debug(1'b1);
      run_random_phase(PH_STEADY, 0, 0);

      // Only one stop can take effect since reset is applied once; pick which
      @(posedge clock);
      phase      = PH_STOP;
      allow_stop = 1'b1;
      halt_first = 1'($urandom_range(0, 1));
      if (halt_first)
         queue_instr(16'h0000);
      queue_instr({4'(ebcpu_pkg::OP_LRC), 4'd3, 8'h80 | 8'($urandom_range(0, 127))});
      queue_instr(instr_word(ebcpu_pkg::OP_STR, 4'd1, 4'd3, 4'd2));
      queue_instr(16'h0000);
      repeat (8)
         queue_instr(16'($urandom_range(0, 65535)));
      drain();
      repeat (20) @(posedge clock);

      $display("summary: %0d results checked, %0d register writes, %0d jumps,",
               checked_count, write_count, jump_count);
      $display("summary: %0d stores, %0d breaks, %0d-cycle receiver hold, stopped by %s",
               store_count, break_count, HOLD_CYCLES, halt_first ? "halt" : "ROM store");
      if (fail_count == 0) begin
         $display("eight_bit_cpu_execute regression: pass");
      end else begin
         $display("eight_bit_cpu_execute regression: fail");
      end
      $finish;
   end

endmodule
